/* design/lpbm_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page buffer manager package
// Shared payload types, slot field widths and the compare unit's result type.
// ----------------------------------------------------------------------------
package lpbm_pkg;

	localparam int TAG_W   = 32;
	localparam int STAMP_W = 31;
	localparam int SIDX_W  = 4;

	// visit stamps and the access counter clear when the counter reaches this
	localparam logic [STAMP_W-1:0] STAMP_LIMIT = STAMP_W'(1) << 30;

	typedef struct packed {
		logic [TAG_W-1:0] page_number;
		logic             will_edit;
	} req_t;

	typedef struct packed {
		logic [SIDX_W-1:0] slot_index;
		logic              hit;
		logic              write_back;
		logic [TAG_W-1:0]  evicted_page;
	} rsp_t;

	// one slot as seen by the compare unit
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} slot_view_t;

	typedef struct packed {
		logic match;
		logic empty;
		logic better;
	} cmp_t;

endpackage

/* design/lpbm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpbm_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/lpbm_slot_cmp.sv */
// ----------------------------------------------------------------------------
// Slot compare unit
// Judges one slot per cycle: tag hit, empty slot, or a new smallest stamp.
// ----------------------------------------------------------------------------
module lpbm_slot_cmp (
	input  lpbm_pkg::slot_view_t           slot,
	input  logic [lpbm_pkg::TAG_W-1:0]     page,
	input  logic [lpbm_pkg::STAMP_W-1:0]   best_stamp,
	input  logic                           first,
	output lpbm_pkg::cmp_t                 res
);

	import lpbm_pkg::*;

	always_comb begin
		res.match  = slot.valid && (slot.tag == page);
		res.empty  = !slot.valid;
		// strict less keeps the lowest numbered slot on ties
		res.better = slot.valid && (first || (slot.stamp < best_stamp));
	end

endmodule

/* design/lru_page_buffer_manager_top.sv */
// ----------------------------------------------------------------------------
// LRU page buffer manager
// Requests are handled one at a time: a new request is taken only in the idle
// state, after the last one's update; the slot store has a single read port,
// so the scan visits one slot per cycle, then the update state writes.
// Reset: all slots empty, stamps and access counter zero; no clearing pass,
// the block takes a request in the first cycle after reset.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager_top #(
	parameter int SLOTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lpbm_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lpbm_pkg::rsp_t out_data
);

	import lpbm_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int RAM_W = TAG_W + STAMP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	state_t state_q;

	// request held for the whole scan
	req_t req_q;

	// scan sequencer: cnt_q is the next read address, _s1 the slot being judged
	logic [CNT_W-1:0] cnt_q;
	logic             eval_vld_s1;
	logic [IDX_W-1:0] eval_idx_s1;

	// scan results
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               empty_found_q;
	logic [IDX_W-1:0]   empty_idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [TAG_W-1:0]   best_tag_q;
	logic               best_edited_q;

	// per-slot flags; live_q marks a stamp written since the last clear
	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   edited_q;
	logic [SLOTS-1:0]   live_q;
	logic [STAMP_W-1:0] access_cnt_q;

	logic       out_valid_q;
	rsp_t       out_data_q;

	// slot store: {tag, stamp}
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [RAM_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [RAM_W-1:0] ram_rdata;

	logic       scan_last;
	slot_view_t ev_slot;
	cmp_t       ev_res;

	logic               upd_fire;
	logic [IDX_W-1:0]   chosen;
	logic               wb;
	logic [STAMP_W-1:0] cnt_next;
	rsp_t               rsp;

	lpbm_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Judge the slot whose data came back from the store this cycle.
	// An unwritten stamp, or one from before the last clear, reads as zero.
	always_comb begin
		ev_slot.valid = valid_q[eval_idx_s1];
		ev_slot.tag   = ram_rdata[STAMP_W +: TAG_W];
		ev_slot.stamp = live_q[eval_idx_s1] ? ram_rdata[STAMP_W-1:0] : '0;
	end

	lpbm_slot_cmp u_cmp (
		.slot      (ev_slot),
		.page      (req_q.page_number),
		.best_stamp(best_stamp_q),
		.first     (eval_idx_s1 == '0),
		.res       (ev_res)
	);

	assign scan_last = (cnt_q == CNT_W'(SLOTS));
	assign ram_re    = (state_q == ST_SCAN) && !scan_last;
	assign ram_raddr = cnt_q[IDX_W-1:0];

	// Pick the slot: hit first, then first empty slot, then least recently used.
	always_comb begin
		priority if (hit_found_q) begin
			chosen = hit_idx_q;
		end else if (empty_found_q) begin
			chosen = empty_idx_q;
		end else begin
			chosen = best_idx_q;
		end
		wb                = !hit_found_q && !empty_found_q && best_edited_q;
		cnt_next          = access_cnt_q + STAMP_W'(1);
		rsp.slot_index    = SIDX_W'(chosen);
		rsp.hit           = hit_found_q;
		rsp.write_back    = wb;
		rsp.evicted_page  = wb ? best_tag_q : '0;
	end

	// Update only when the output register is free to take the result.
	assign upd_fire  = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign ram_we    = upd_fire;
	assign ram_waddr = chosen;
	assign ram_wdata = {req_q.page_number, cnt_next};

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			eval_vld_s1   <= 1'b0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			valid_q       <= '0;
			edited_q      <= '0;
			live_q        <= '0;
			access_cnt_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// load a new result, or drop the old one once its transfer completes
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						// latch the request and clear scan results
						req_q         <= in_data;
						cnt_q         <= '0;
						eval_vld_s1   <= 1'b0;
						hit_found_q   <= 1'b0;
						empty_found_q <= 1'b0;
						best_idx_q    <= '0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance the read address, one slot per cycle
					eval_vld_s1 <= !scan_last;
					eval_idx_s1 <= cnt_q[IDX_W-1:0];
					if (!scan_last) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						state_q <= ST_UPDATE;
					end
					if (eval_vld_s1) begin
						if (ev_res.match && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= eval_idx_s1;
						end
						if (ev_res.empty && !empty_found_q) begin
							empty_found_q <= 1'b1;
							empty_idx_q   <= eval_idx_s1;
						end
						if (ev_res.better) begin
							best_idx_q    <= eval_idx_s1;
							best_stamp_q  <= ev_slot.stamp;
							best_tag_q    <= ev_slot.tag;
							best_edited_q <= edited_q[eval_idx_s1];
						end
					end
				end
				ST_UPDATE: begin
					if (upd_fire) begin
						valid_q[chosen] <= 1'b1;
						// a miss loads the page clean before the edit mark
						edited_q[chosen] <= req_q.will_edit
							|| (hit_found_q && edited_q[chosen]);
						// store the stamp, then clear all stamps at the limit
						if (cnt_next == STAMP_LIMIT) begin
							live_q       <= '0;
							access_cnt_q <= '0;
						end else begin
							live_q[chosen] <= 1'b1;
							access_cnt_q   <= cnt_next;
						end
						out_data_q  <= rsp;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a request transfer always starts a scan, so the block is busy next cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block ready right after a request transfer");

	// the counter is cleared when it reaches the limit
	a_counter_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		access_cnt_q < STAMP_LIMIT)
		else $error("access counter reached the stamp limit");

	// a live stamp only belongs to an occupied slot
	a_live_in_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(live_q & ~valid_q) == 0)
		else $error("stamp marked live in an empty slot");

	// a write-back only comes with a miss
	a_wb_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.write_back) |-> !out_data.hit)
		else $error("write-back reported on a hit");

endmodule
